@@ rtl/wsrx_pkg.sv @@
// Package for the websocket receive deframer: opcodes, result kinds and parser phases.
// It depends on nothing and is imported by the deframer and its checker.
package wsrx_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned OpW   = 4;

  localparam logic [OpW-1:0]   OpText     = 4'h1;
  localparam logic [OpW-1:0]   OpClose    = 4'h8;
  localparam logic [OpW-1:0]   OpPing     = 4'h9;
  localparam logic [ByteW-1:0] PongFinHdr = 8'h8A;
  localparam logic [ByteW-1:0] LenExt16   = 8'd126;

  localparam logic [KindW-1:0] KindText   = 3'd0;
  localparam logic [KindW-1:0] KindEmpty  = 3'd1;
  localparam logic [KindW-1:0] KindPong   = 3'd2;
  localparam logic [KindW-1:0] KindClose  = 3'd3;
  localparam logic [KindW-1:0] KindBadLen = 3'd4;

  typedef enum logic [4:0] {
    PhHdr0    = 5'b00001,
    PhHdr1    = 5'b00010,
    PhExtHi   = 5'b00100,
    PhExtLo   = 5'b01000,
    PhPayload = 5'b10000
  } phase_e;

endpackage

@@ rtl/websocket_rx_deframer_unit.sv @@
// Websocket receive deframer: parses frame headers, streams text and pong words and reports status words.
// It depends on wsrx_pkg for opcodes, result kinds and the parser phase type.
//
// Channel   Handshake                Payload
// input     in_valid_i / in_ready_o  data_byte_i
// output    out_valid_o / out_ready_i kind_o, byte_value_o, frame_last_o
//
// Each word passes an input register and a result register, and one word can be accepted
// in every cycle while the result word is not stalled.
// The header and payload logic sits between the two registers.
// Reset clears the parser, the halt flag and both valid flags; no clearing pass is needed.
// A stalled result holds the input register, which then holds the input channel.
module websocket_rx_deframer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsrx_pkg::ByteW-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wsrx_pkg::KindW-1:0]   kind_o,
  output logic [wsrx_pkg::ByteW-1:0]   byte_value_o,
  output logic                         frame_last_o
);
  import wsrx_pkg::*;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             out_free;
  logic             s1_advance;

  phase_e           phase_q, phase_d;
  logic [OpW-1:0]   opcode_q, opcode_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [ByteW-1:0] ext_hi_q, ext_hi_d;
  logic             halted_q, halted_d;

  logic             res_valid;
  logic [KindW-1:0] res_kind;
  logic [ByteW-1:0] res_byte;
  logic             res_last;
  logic             fin;
  logic [LenW-1:0]  fin_len;
  logic [LenW-1:0]  left_dec;

  logic             out_valid_q;
  logic [KindW-1:0] kind_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign left_dec   = left_q - LenW'(1);

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    left_d    = left_q;
    ext_hi_d  = ext_hi_q;
    halted_d  = halted_q;
    res_valid = 1'b0;
    res_kind  = KindText;
    res_byte  = '0;
    res_last  = 1'b0;
    fin       = 1'b0;
    fin_len   = '0;
    if (s1_advance && !halted_q) begin
      unique case (phase_q)
        PhHdr1: begin
          if (s1_byte_q > LenExt16) begin
            halted_d  = 1'b1;
            phase_d   = PhHdr0;
            res_valid = 1'b1;
            res_kind  = KindBadLen;
          end else if (s1_byte_q == LenExt16) begin
            phase_d = PhExtHi;
            if (opcode_q == OpPing) begin
              res_valid = 1'b1;
              res_kind  = KindPong;
              res_byte  = s1_byte_q;
            end
          end else begin
            fin     = 1'b1;
            fin_len = {{(LenW-ByteW){1'b0}}, s1_byte_q};
          end
        end
        PhExtHi: begin
          ext_hi_d = s1_byte_q;
          phase_d  = PhExtLo;
          if (opcode_q == OpPing) begin
            res_valid = 1'b1;
            res_kind  = KindPong;
            res_byte  = s1_byte_q;
          end
        end
        PhExtLo: begin
          fin     = 1'b1;
          fin_len = {ext_hi_q, s1_byte_q};
        end
        PhPayload: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PhHdr0;
          end
          if (opcode_q == OpText) begin
            res_valid = 1'b1;
            res_kind  = KindText;
            res_byte  = s1_byte_q;
            res_last  = (left_dec == '0);
          end else if (opcode_q == OpPing) begin
            res_valid = 1'b1;
            res_kind  = KindPong;
            res_byte  = s1_byte_q;
            res_last  = (left_dec == '0);
          end else if (opcode_q == OpClose && left_dec == '0) begin
            halted_d  = 1'b1;
            res_valid = 1'b1;
            res_kind  = KindClose;
          end
        end
        default: begin
          opcode_d = s1_byte_q[OpW-1:0];
          phase_d  = PhHdr1;
          if (s1_byte_q[OpW-1:0] == OpPing) begin
            res_valid = 1'b1;
            res_kind  = KindPong;
            res_byte  = PongFinHdr;
          end
        end
      endcase
      if (fin) begin
        if (fin_len == '0) begin
          phase_d = PhHdr0;
          if (opcode_q == OpText) begin
            res_valid = 1'b1;
            res_kind  = KindEmpty;
          end else if (opcode_q == OpPing) begin
            res_valid = 1'b1;
            res_kind  = KindPong;
            res_byte  = s1_byte_q;
            res_last  = 1'b1;
          end else if (opcode_q == OpClose) begin
            halted_d  = 1'b1;
            res_valid = 1'b1;
            res_kind  = KindClose;
          end
        end else begin
          left_d  = fin_len;
          phase_d = PhPayload;
          if (opcode_q == OpPing) begin
            res_valid = 1'b1;
            res_kind  = KindPong;
            res_byte  = s1_byte_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhHdr0;
      opcode_q    <= '0;
      left_q      <= '0;
      ext_hi_q    <= '0;
      halted_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_advance && res_valid;
      end
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      left_q   <= left_d;
      ext_hi_q <= ext_hi_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_byte_q <= data_byte_i;
    end
    if (out_free) begin
      kind_q <= res_kind;
      byte_q <= res_byte;
      last_q <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign byte_value_o = byte_q;
  assign frame_last_o = last_q;

endmodule

@@ rtl/wsrx_checker.sv @@
// Port checker for the websocket receive deframer, bound to the top level.
// It depends on wsrx_pkg for the result kind codes.
module wsrx_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [wsrx_pkg::KindW-1:0]   kind_o,
  input logic [wsrx_pkg::ByteW-1:0]   byte_value_o,
  input logic                         frame_last_o
);
  import wsrx_pkg::*;

  // A result word that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(byte_value_o)
      && $stable(frame_last_o))
    else $error("result word changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= KindBadLen)
    else $error("result kind out of range");

  // Status kinds carry neither a byte nor an end-of-frame mark.
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindEmpty || kind_o == KindClose || kind_o == KindBadLen)
      |-> byte_value_o == '0 && !frame_last_o)
    else $error("status word carries payload");

  // After a close or bad length has been taken the block is halted.
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (kind_o == KindClose || kind_o == KindBadLen)
      |=> !out_valid_o)
    else $error("result word after halt");

endmodule

bind websocket_rx_deframer_unit wsrx_checker u_wsrx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .byte_value_o (byte_value_o),
  .frame_last_o (frame_last_o)
);
